// ===== design/unv_pkg.sv =====
// ----------------------------------------------------------------------------
// unv_pkg
// Shared types and constants for the UTF-8 name validator.
// ----------------------------------------------------------------------------
package unv_pkg;

	// Verdict cause codes, in priority order
	typedef enum logic [2:0] {
		CAUSE_OK        = 3'd0,
		CAUSE_MALFORMED = 3'd1,
		CAUSE_CONTROL   = 3'd2,
		CAUSE_EMPTY     = 3'd3,
		CAUSE_TOO_LONG  = 3'd4
	} cause_t;

	// Sticky per-string error
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_MALFORMED = 2'd1,
		ERR_CONTROL   = 2'd2
	} err_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ALLOW_EMPTY = 2'd0,
		REG_MAX_CHARS   = 2'd1
	} reg_idx_t;

	localparam int unsigned CP_W   = 9;
	localparam int unsigned BYTE_W = 11;

	localparam logic [CP_W-1:0]   CP_SAT   = 9'd256;
	localparam logic [BYTE_W-1:0] BYTE_SAT = 11'd2047;

	localparam logic [7:0] CONTROL_LIMIT = 8'd32;
	localparam logic [7:0] DEL_BYTE      = 8'd127;

	localparam logic        RESET_ALLOW_EMPTY = 1'b1;
	localparam logic [7:0]  RESET_MAX_CHARS   = 8'd16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_empty;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0]        pend;
		err_t              err;
		logic [CP_W-1:0]   cp;
		logic [BYTE_W-1:0] bytes;
	} str_state_t;

	typedef struct packed {
		logic            valid_res;
		cause_t          cause;
		logic [CP_W-1:0] char_count;
	} result_t;

endpackage

// ===== design/unv_in_if.sv =====
// ----------------------------------------------------------------------------
// unv_in_if
// Byte stream channel: one string byte per beat.
// ----------------------------------------------------------------------------
interface unv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_empty;
	logic       last;

	modport source (output valid, output data_byte, output is_empty, output last,
		input ready);
	modport sink (input valid, input data_byte, input is_empty, input last,
		output ready);
endinterface

// ===== design/unv_out_if.sv =====
// ----------------------------------------------------------------------------
// unv_out_if
// Verdict channel: one beat per string.
// ----------------------------------------------------------------------------
interface unv_out_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [2:0] cause;
	logic [8:0] char_count;

	modport source (output valid, output valid_res, output cause, output char_count,
		input ready);
	modport sink (input valid, input valid_res, input cause, input char_count,
		output ready);
endinterface

// ===== design/unv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// unv_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface unv_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] wr_index;
	logic [7:0] wr_data;

	modport source (output valid, output wr_index, output wr_data, input ready);
	modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== design/unv_step.sv =====
// ----------------------------------------------------------------------------
// unv_step
// Per-byte state update and end-of-string verdict (combinational).
// ----------------------------------------------------------------------------
module unv_step (
	input  unv_pkg::str_state_t cur,
	input  unv_pkg::item_t      item,
	input  logic                allow_empty,
	input  logic [7:0]          max_chars,
	output unv_pkg::str_state_t nxt,
	output unv_pkg::result_t    res
);

	unv_pkg::str_state_t st;
	unv_pkg::cause_t     cause;
	logic                is_cont;
	logic [9:0]          byte_limit;
	logic [7:0]          b;

	assign b          = item.data_byte;
	assign is_cont    = (b[7:6] == 2'b10);
	assign byte_limit = {max_chars, 2'b00};

	always_comb begin
		st = cur;
		if (!item.is_empty) begin
			if (!is_cont && (cur.cp < unv_pkg::CP_SAT)) begin
				st.cp = cur.cp + 9'd1;
			end
			if (cur.bytes != unv_pkg::BYTE_SAT) begin
				st.bytes = cur.bytes + 11'd1;
			end
			if (((b < unv_pkg::CONTROL_LIMIT) || (b == unv_pkg::DEL_BYTE))
					&& (cur.err == unv_pkg::ERR_NONE)) begin
				st.err = unv_pkg::ERR_CONTROL;
			end
			// Continuation expected: consume it or flag the sequence as broken
			if (cur.pend != 2'd0) begin
				if (is_cont) begin
					st.pend = cur.pend - 2'd1;
				end else begin
					st.err  = unv_pkg::ERR_MALFORMED;
					st.pend = 2'd0;
				end
			end else if (b[7]) begin
				unique casez (b)
					8'b110?????: st.pend = 2'd1;
					8'b1110????: st.pend = 2'd2;
					8'b11110???: st.pend = 2'd3;
					default: begin
						st.err  = unv_pkg::ERR_MALFORMED;
						st.pend = 2'd0;
					end
				endcase
			end
		end
	end

	always_comb begin
		if ((st.err == unv_pkg::ERR_MALFORMED) || (st.pend != 2'd0)) begin
			cause = unv_pkg::CAUSE_MALFORMED;
		end else if (st.err == unv_pkg::ERR_CONTROL) begin
			cause = unv_pkg::CAUSE_CONTROL;
		end else if (st.cp == '0) begin
			cause = allow_empty ? unv_pkg::CAUSE_OK : unv_pkg::CAUSE_EMPTY;
		end else if ((st.cp > {1'b0, max_chars}) || (st.bytes > {1'b0, byte_limit})) begin
			cause = unv_pkg::CAUSE_TOO_LONG;
		end else begin
			cause = unv_pkg::CAUSE_OK;
		end
	end

	assign res.valid_res  = (cause == unv_pkg::CAUSE_OK);
	assign res.cause      = cause;
	assign res.char_count = st.cp;

	// The verdict closes the string: start the next one from zero
	assign nxt = item.last ? '0 : st;

endmodule

// ===== design/utf8_name_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_name_validator
// Streams a string byte by byte, checks UTF-8 framing, control bytes, empty
// strings and length limits, and emits one verdict beat per string.
// ----------------------------------------------------------------------------
// The verdict for a string passes through the input register, then the result
// register, and is offered on the verdict channel from the result register.
// Throughput: one byte per cycle; a closing byte holds in the input register
// only while the previous verdict still waits untaken in the result register.
// Reset (arst_n low): string state and all valid flags clear at once;
// allow_empty returns to 1 and max_chars to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_name_validator (
	input logic       clk,
	input logic       arst_n,
	unv_in_if.sink    in_ch,
	unv_out_if.source out_ch,
	unv_cfg_if.sink   cfg
);

	// Configuration registers
	logic       allow_empty_q;
	logic [7:0] max_chars_q;

	// Input register stage
	unv_pkg::item_t item_s1;
	logic           valid_s1;

	// Running string state
	unv_pkg::str_state_t state_q;
	unv_pkg::str_state_t state_nxt;

	// Result register
	unv_pkg::result_t res_nxt;
	unv_pkg::result_t res_q;
	logic             out_valid_q;

	logic adv_s1;
	logic in_fire;

	// Configuration writes are always taken; indexes past the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_empty_q <= unv_pkg::RESET_ALLOW_EMPTY;
			max_chars_q   <= unv_pkg::RESET_MAX_CHARS;
		end else if (cfg.valid) begin
			unique case (cfg.wr_index)
				unv_pkg::REG_ALLOW_EMPTY: allow_empty_q <= cfg.wr_data[0];
				unv_pkg::REG_MAX_CHARS:   max_chars_q   <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// Advance the staged byte unless it closes a string and the result
	// register still holds a verdict nobody has taken
	assign adv_s1  = valid_s1 && (!item_s1.last || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign in_fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Capture the incoming beat's payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.is_empty  <= in_ch.is_empty;
			item_s1.last      <= in_ch.last;
		end
	end

	unv_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.allow_empty (allow_empty_q),
		.max_chars   (max_chars_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// Commit the per-byte update as the staged beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on a closing beat, drop once the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last) begin
			res_q <= res_nxt;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.valid_res  = res_q.valid_res;
	assign out_ch.cause      = 3'(res_q.cause);
	assign out_ch.char_count = res_q.char_count;

endmodule

// ===== dv/unv_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unv_verdict_checker
// Watches the byte, verdict and register channels of the name validator. It
// keeps its own copy of the string state and the limit registers, works out
// the verdict of every string, and compares each verdict beat with the oldest
// outstanding one.
// ----------------------------------------------------------------------------
module unv_verdict_checker (
	input  logic clk,
	input  logic arst_n,
	unv_in_if    in_ch,
	unv_out_if   out_ch,
	unv_cfg_if   cfg,
	output int   fail_count,
	output int   owed,
	output int   verdicts_seen
);

	logic                       allow_empty_q;
	logic [7:0]                 max_chars_q;
	logic [1:0]                 cont_left;
	unv_pkg::err_t              str_err;
	logic [unv_pkg::CP_W-1:0]   cp_seen;
	logic [unv_pkg::BYTE_W-1:0] bytes_seen;
	unv_pkg::result_t           verdict_q[$];
	int                         mism;
	int                         seen;

	always @(posedge clk or negedge arst_n) begin
		unv_pkg::result_t want;
		logic [7:0]       b;
		logic             cont;
		unv_pkg::cause_t  why;
		if (!arst_n) begin
			allow_empty_q = unv_pkg::RESET_ALLOW_EMPTY;
			max_chars_q   = unv_pkg::RESET_MAX_CHARS;
			cont_left     = 2'd0;
			str_err       = unv_pkg::ERR_NONE;
			cp_seen       = '0;
			bytes_seen    = '0;
			verdict_q.delete();
			mism          = 0;
			seen          = 0;
		end else begin
			// Verdict beat: compare with the oldest outstanding verdict
			if (out_ch.valid && out_ch.ready) begin
				seen++;
				if (verdict_q.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("%0t: verdict with none outstanding: %s%0d %s%0d %s%0d",
							$realtime, "valid_res=", out_ch.valid_res,
							"cause=", out_ch.cause, "chars=", out_ch.char_count);
				end else begin
					want = verdict_q.pop_front();
					if (out_ch.valid_res !== want.valid_res || out_ch.cause !== want.cause ||
						out_ch.char_count !== want.char_count) begin
						mism++;
						if (mism <= 10) begin
							$display("%0t: verdict mismatch: expected %s%0d %s%0d %s%0d,",
								$realtime, "valid_res=", want.valid_res,
								"cause=", want.cause, "chars=", want.char_count);
							$display("    got valid_res=%0d cause=%0d chars=%0d",
								out_ch.valid_res, out_ch.cause, out_ch.char_count);
						end
					end
				end
			end

			// Register write
			if (cfg.valid && cfg.ready) begin
				case (cfg.wr_index)
					unv_pkg::REG_ALLOW_EMPTY: allow_empty_q = cfg.wr_data[0];
					unv_pkg::REG_MAX_CHARS:   max_chars_q   = cfg.wr_data;
					default: ;
				endcase
			end

			// Byte beat: advance the string state
			if (in_ch.valid && in_ch.ready) begin
				if (!in_ch.is_empty) begin
					b    = in_ch.data_byte;
					cont = (b[7:6] == 2'b10);
					if (!cont && cp_seen < unv_pkg::CP_SAT)
						cp_seen++;
					if (bytes_seen < unv_pkg::BYTE_SAT)
						bytes_seen++;
					// a control byte only marks a clean string
					if ((b < unv_pkg::CONTROL_LIMIT || b == unv_pkg::DEL_BYTE) &&
						str_err == unv_pkg::ERR_NONE)
						str_err = unv_pkg::ERR_CONTROL;
					if (cont_left != 2'd0) begin
						if (cont) begin
							cont_left--;
						end else begin
							str_err   = unv_pkg::ERR_MALFORMED;
							cont_left = 2'd0;
						end
					end else if (b[7]) begin
						if (b[7:5] == 3'b110)
							cont_left = 2'd1;
						else if (b[7:4] == 4'b1110)
							cont_left = 2'd2;
						else if (b[7:3] == 5'b11110)
							cont_left = 2'd3;
						else
							str_err = unv_pkg::ERR_MALFORMED;
					end
				end
				if (in_ch.last) begin
					if (str_err == unv_pkg::ERR_MALFORMED || cont_left != 2'd0)
						why = unv_pkg::CAUSE_MALFORMED;
					else if (str_err == unv_pkg::ERR_CONTROL)
						why = unv_pkg::CAUSE_CONTROL;
					else if (cp_seen == '0)
						why = allow_empty_q ? unv_pkg::CAUSE_OK : unv_pkg::CAUSE_EMPTY;
					else if (cp_seen > {1'b0, max_chars_q} ||
						bytes_seen > {1'b0, max_chars_q, 2'b00})
						why = unv_pkg::CAUSE_TOO_LONG;
					else
						why = unv_pkg::CAUSE_OK;
					want.valid_res  = (why == unv_pkg::CAUSE_OK);
					want.cause      = why;
					want.char_count = cp_seen;
					verdict_q = {verdict_q, want};
					cont_left  = 2'd0;
					str_err    = unv_pkg::ERR_NONE;
					cp_seen    = '0;
					bytes_seen = '0;
				end
			end
		end
		fail_count    <= mism;
		owed          <= verdict_q.size();
		verdicts_seen <= seen;
	end

endmodule

// ===== dv/utf8_name_validator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_name_validator_test
// Drives strings into the name validator one byte beat at a time: a short
// directed set of edge cases, then random strings under several limit
// settings, with random gaps on both sides and one long verdict hold-off.
// Checking lives in unv_verdict_checker; this module only makes stimulus
// and reports the outcome.
// ----------------------------------------------------------------------------
module utf8_name_validator_test;

	localparam int WATCH_LIMIT = 2000; // cycles with no beat on any channel
	localparam int HOLD_CYCLES = 120;  // receiver hold-off to back up the input
	localparam int HOLD_AFTER  = 16;   // verdicts taken before the hold-off
	localparam int PHASE_BEATS = 20;   // random byte beats per limit setting
	localparam int SETTLE      = 4;    // drain margin after the last verdict

	logic clk;
	logic arst_n;

	unv_in_if  in_ch ();
	unv_out_if out_ch ();
	unv_cfg_if cfg ();

	int fail_count;
	int owed;
	int verdicts_seen;

	unv_pkg::item_t str_q[$];   // bytes of the string being assembled
	bit             rush;       // no gaps between beats of the current string
	bit             streaming;  // byte side is in a random block, not draining
	int             beats_sent;
	int             strings_sent;
	int             settings_used;
	int             idle_cycles;

	utf8_name_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	unv_verdict_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.cfg           (cfg),
		.fail_count    (fail_count),
		.owed          (owed),
		.verdicts_seen (verdicts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: end the run if no beat moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("Timeout: no beat for %0d cycles, %0d verdicts outstanding",
				idle_cycles, owed);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Append one raw byte to the string
	task automatic add_byte(input logic [7:0] b);
		unv_pkg::item_t it;
		it.data_byte = b;
		it.is_empty  = 1'b0;
		it.last      = 1'b0;
		str_q = {str_q, it};
	endtask

	// Append an empty marker; its byte field carries noise
	task automatic add_marker();
		unv_pkg::item_t it;
		it.data_byte = 8'($urandom_range(0, 255));
		it.is_empty  = 1'b1;
		it.last      = 1'b0;
		str_q = {str_q, it};
	endtask

	// Append a codepoint of len bytes with random payload; cut drops
	// some of its continuation bytes to leave the sequence short
	task automatic add_char(input int len, input bit cut);
		int conts;
		case (len)
			1: add_byte(8'($urandom_range(32, 126)));
			2: add_byte({3'b110, 5'($urandom_range(0, 31))});
			3: add_byte({4'b1110, 4'($urandom_range(0, 15))});
			default: add_byte({5'b11110, 3'($urandom_range(0, 7))});
		endcase
		conts = len - 1;
		if (cut && conts > 0)
			conts = conts - $urandom_range(1, conts);
		repeat (conts)
			add_byte({2'b10, 6'($urandom_range(0, 63))});
	endtask

	// Offer one beat; valid stays high after acceptance so that a
	// back-to-back beat never lowers and raises it in one step
	task automatic send_beat(input unv_pkg::item_t it);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= it.data_byte;
		in_ch.is_empty  <= it.is_empty;
		in_ch.last      <= it.last;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
	endtask

	// Flag the final beat, send the whole string and clear it
	task automatic ship_string();
		str_q[str_q.size() - 1].last = 1'b1;
		rush = ($urandom_range(0, 3) == 0);
		foreach (str_q[i])
			send_beat(str_q[i]);
		str_q.delete();
		strings_sent++;
	endtask

	// Drop valid, wait for every verdict, then let the pipe drain
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both limit registers back to back on the write channel
	task automatic set_limits(input logic allow, input logic [7:0] maxc);
		cfg.valid    <= 1'b1;
		cfg.wr_index <= unv_pkg::REG_ALLOW_EMPTY;
		cfg.wr_data  <= {7'd0, allow};
		do @(posedge clk); while (!cfg.ready);
		cfg.wr_index <= unv_pkg::REG_MAX_CHARS;
		cfg.wr_data  <= maxc;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Verdict side: random stalls, quiet stretches, one long hold-off
	initial begin
		int  stall;
		int  taken;
		int  quiet;
		bit  held;
		out_ch.ready <= 1'b0;
		taken = 0;
		quiet = 0;
		held  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken >= HOLD_AFTER && !held && streaming) begin
				// back up the block until it stalls the byte side
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end else if (quiet > 0) begin
				stall = 0;
				quiet--;
			end else begin
				stall = $urandom_range(0, 13);
				if ($urandom_range(0, 19) == 0)
					quiet = $urandom_range(10, 30);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			taken++;
		end
	end

	// Byte side and register writes
	initial begin
		logic       ph_allow [7];
		logic [7:0] ph_max   [7];
		int         phase_start;
		int         cap;
		int         near;
		int         n;
		int         pick;
		bit         wide;

		ph_allow = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		ph_max   = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd3, 8'd8, 8'd16};
		ph_max[6] = 8'($urandom_range(1, 255));

		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.data_byte <= 8'd0;
		in_ch.is_empty  <= 1'b0;
		in_ch.last      <= 1'b0;
		cfg.valid       <= 1'b0;
		cfg.wr_index    <= unv_pkg::REG_ALLOW_EMPTY;
		cfg.wr_data     <= 8'd0;
		rush            = 1'b0;
		streaming       = 1'b0;
		beats_sent      = 0;
		strings_sent    = 0;
		settings_used   = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings under the reset limits (empty allowed, 16 chars)
		add_byte(8'h41); ship_string();                                  // plain ASCII
		add_marker(); ship_string();                                     // empty, allowed
		add_byte(8'hC3); add_byte(8'hA9); ship_string();                 // two-byte char
		add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC); ship_string(); // three-byte char
		add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
		ship_string();                                                   // four-byte char
		add_byte(8'h1F); add_byte(8'hFF); ship_string();   // malformed replaces control
		add_byte(8'hFF); add_byte(8'h7F); ship_string();   // control never replaces malformed
		add_byte(8'h20); add_byte(8'h00); ship_string();   // control byte, lowest value
		add_byte(8'hE2); add_byte(8'h41); ship_string();   // bad continuation byte
		add_byte(8'hC3); ship_string();                    // sequence cut short
		add_byte(8'h80); ship_string();                    // stray continuation byte
		add_byte(8'h41); add_marker(); ship_string();      // marker closes a non-empty string
		add_byte(8'hF8); ship_string();                    // lead byte out of range
		settle();

		// Random strings, one block of them per limit setting
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0)
				set_limits(ph_allow[ph], ph_max[ph]);
			cap = ph_max[ph];
			if (!ph_allow[ph]) begin
				add_marker();
				ship_string();
			end
			if (cap == 255) begin
				// push the codepoint count past saturation
				repeat (257) add_byte(8'($urandom_range(8'h61, 8'h7A)));
				ship_string();
			end
			streaming   = 1'b1;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				if ($urandom_range(0, 15) == 0) begin
					add_marker();
				end else begin
					near = (cap > 20) ? 20 : cap;
					if ($urandom_range(0, 3) == 0)
						n = $urandom_range((near > 2) ? near - 2 : 1, near + 3);
					else
						n = $urandom_range(1, 8);
					wide = ($urandom_range(0, 3) == 0);
					repeat (n) begin
						pick = $urandom_range(0, 99);
						if (pick < 86)
							add_char(wide ? 4 : $urandom_range(1, 4), 1'b0);
						else if (pick < 90)
							add_byte(8'($urandom_range(0, 255)));
						else if (pick < 94)
							add_byte(($urandom_range(0, 4) == 0) ? unv_pkg::DEL_BYTE :
								8'($urandom_range(0, 31)));
						else if (pick < 97)
							add_char($urandom_range(2, 4), 1'b1);
						else
							add_marker();
					end
				end
				ship_string();
			end
			streaming = 1'b0;
			settle();
		end

		$display("Covered %0d strings in %0d byte beats over %0d limit settings,",
			strings_sent, beats_sent, settings_used);
		$display("with %0d verdicts checked and one long verdict hold-off.", verdicts_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
